// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that holds on every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

`endif

// ===== rtl/core/rne_pkg.sv =====
// Types, constants and the glyph function of the radix-N ASCII encoder.
package rne_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int VALUE_PORT_W = 64;
   localparam int BASE_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W = 7;
   localparam int MAX_DIGITS = 64;
   localparam int PTR_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(62);
   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(62);
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(61);

   localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = CHAR_W'(65);
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(97);
   localparam logic [CHAR_W-1:0] CHAR_NONE = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_POP,
      ST_LOAD,
      ST_ERR
   } enc_state_type;

   typedef struct packed {
      logic start_first;
      logic start_next;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic nonzero;
   } div_stat_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic last;
   } stk_stat_type;

   // Map a digit value to its ASCII code: 0-9, A-Z, a-z.
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] dc;
      logic [CHAR_W-1:0] dw;
      dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
      dw = CHAR_W'(dc);
      if (dc < DIGIT_W'(10)) begin
         glyph = CHAR_ZERO + dw;
      end else if (dc < DIGIT_W'(36)) begin
         glyph = CHAR_UPPER_A + dw - CHAR_W'(10);
      end else begin
         glyph = CHAR_LOWER_A + dw - CHAR_W'(36);
      end
   endfunction

endpackage

// ===== rtl/core/rne_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit base.
module rne_serial_div
   import rne_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  div_ctl_type            ctl,
   input  logic [VALUE_WIDTH-1:0] value,
   input  logic [BASE_W-1:0]      base,
   output div_stat_type           stat,
   output logic [DIGIT_W-1:0]     remainder
);

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [BASE_W-1:0]      rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   nz_ff, nz_in;
   logic [BASE_W:0]        trial;
   logic                   ge;
   logic [BASE_W:0]        diff;
   logic                   final_bit;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign ge = (trial >= {1'b0, base});
   assign diff = trial - {1'b0, base};
   assign final_bit = busy_ff && (cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1));

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in = nz_ff;
      if (ctl.start_first || ctl.start_next) begin
         if (ctl.start_first) begin
            quot_in = value;
         end
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
         nz_in = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], ge};
         rem_in = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
         nz_in = nz_ff | ge;
         cnt_in = cnt_ff + BIT_CNT_W'(1);
         if (final_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      nz_ff <= nz_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.nonzero = nz_ff;
   assign remainder = DIGIT_W'(rem_ff);

endmodule

// ===== rtl/core/rne_digit_stack.sv =====
// Digit stack: remainders pushed least significant first, popped in reverse.
`include "assert_macros.svh"

module rne_digit_stack
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stk_ctl_type        ctl,
   input  logic [DIGIT_W-1:0] wr_digit,
   output stk_stat_type       stat,
   output logic [DIGIT_W-1:0] rd_digit
);

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]   top_idx;
   logic [DIGIT_W-1:0] rd_ff;

   assign top_idx = depth_ff - CNT_W'(1);

   // Depth count
   always_comb begin
      depth_in = depth_ff;
      if (ctl.push) begin
         depth_in = depth_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         depth_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Storage, write and registered read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[depth_ff[PTR_W-1:0]] <= wr_digit;
      end
      if (ctl.pop) begin
         rd_ff <= mem[top_idx[PTR_W-1:0]];
      end
   end

   assign stat.empty = (depth_ff == '0);
   assign stat.full = (depth_ff == CNT_W'(MAX_DIGITS));
   assign stat.last = (depth_ff == CNT_W'(1));
   assign rd_digit = rd_ff;

   `ASSERT_IMPL(a_no_push_full, ctl.push, !stat.full, "push into full digit stack")
   `ASSERT_IMPL(a_no_pop_empty, ctl.pop, !stat.empty, "pop from empty digit stack")
   `ASSERT_IMPL(a_no_push_pop, ctl.push, !ctl.pop, "push and pop in one cycle")

endmodule

// ===== rtl/core/radix_n_ascii_encoder_unit.sv =====
// Radix-N ASCII encoder top level: control sequencer, base register, result register.
//
// Converts each request value (low VALUE_WIDTH bits) to ASCII digits in the base held in
// csr_write_data's register (reset 62, valid 2..62), most significant digit first, one
// result per digit with rsp_last on the final one; zero gives a single '0'. An invalid
// base gives one result with rsp_bad_base = 1, rsp_digit_char = 0 and rsp_last = 1.
// Work is one request at a time. Each digit comes from one pass of a bit-serial divider
// that retires one quotient bit per cycle and pushes the remainder onto the digit stack;
// each digit is then popped (ST_POP) and loaded into the result register (ST_LOAD),
// which waits while the result side stalls. An invalid base goes through ST_ERR.
// A new request is taken once the previous one's last result is in the output register.
`include "assert_macros.svh"

module radix_n_ascii_encoder_unit
   import rne_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [VALUE_PORT_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHAR_W-1:0]       rsp_digit_char,
   output logic                    rsp_last,
   output logic                    rsp_bad_base,
   input  logic                    csr_write_en,
   input  logic [BASE_W-1:0]       csr_write_data
);

   enc_state_type      state_ff, state_in;
   logic [BASE_W-1:0]  base_ff;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;
   logic               req_accept;
   logic               base_ok;
   logic               out_free;
   div_ctl_type        div_ctl;
   div_stat_type       div_stat;
   logic [DIGIT_W-1:0] div_rem;
   stk_ctl_type        stk_ctl;
   stk_stat_type       stk_stat;
   logic [DIGIT_W-1:0] stk_digit;

   // Base register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_write_en) begin
         base_ff <= csr_write_data;
      end
   end

   assign base_ok = (base_ff >= BASE_MIN) && (base_ff <= BASE_MAX);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   rne_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .value     (req_value[VALUE_WIDTH-1:0]),
      .base      (base_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   rne_digit_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (stk_ctl),
      .wr_digit (div_rem),
      .stat     (stk_stat),
      .rd_digit (stk_digit)
   );

   // Sequencer: divide into the stack, then pop digits to the result register; an invalid base takes the error state
   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      div_ctl = '0;
      stk_ctl = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (base_ok) begin
                  div_ctl.start_first = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               stk_ctl.push = 1'b1;
               // Keep dividing while the quotient is nonzero and room remains
               if (div_stat.nonzero && !stk_stat.full) begin
                  div_ctl.start_next = 1'b1;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            stk_ctl.pop = 1'b1;
            last_in = stk_stat.last;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = glyph(stk_digit);
               rsp_last_in = last_ff;
               rsp_bad_in = 1'b0;
               state_in = last_ff ? ST_IDLE : ST_POP;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = CHAR_NONE;
               rsp_last_in = 1'b1;
               rsp_bad_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload and pop bookkeeping
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_bad_base = rsp_bad_ff;

   `ASSERT_IMPL(a_div_start_idle, div_ctl.start_first || div_ctl.start_next,
      !div_stat.busy, "divider started while busy")
   `ASSERT_IMPL(a_bad_base_form, rsp_valid && rsp_bad_base,
      rsp_last && (rsp_digit_char == CHAR_NONE), "malformed bad base result")
   `ASSERT_NEXT(a_bad_base_path, req_accept && !base_ok, state_ff == ST_ERR,
      "invalid base did not take the error path")
   `ASSERT_IMPL(a_pop_has_data, state_ff == ST_POP, !stk_stat.empty,
      "pop with no digits stored")

endmodule

// ===== test/tb_radix_n_ascii_encoder_unit.sv =====
// Self-checking testbench for the radix-N ASCII encoder: directed and random values over many bases.
module tb_radix_n_ascii_encoder_unit
   import rne_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD = 400;
   localparam int IDLE_MAX = 18;
   localparam int RANDOM_PHASES = 5;
   localparam int RANDOM_PER_PHASE = 15;
   // low VALUE_WIDTH bits of a request value are converted, the rest ignored
   localparam logic [VALUE_PORT_W-1:0] VALUE_KEEP =
      {VALUE_PORT_W{1'b1}} >> (VALUE_PORT_W - VALUE_WIDTH);

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
      logic              bad_base;
   } char_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [VALUE_PORT_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CHAR_W-1:0]       rsp_digit_char;
   logic                    rsp_last;
   logic                    rsp_bad_base;
   logic                    csr_write_en = 1'b0;
   logic [BASE_W-1:0]       csr_write_data = BASE_RESET;

   string glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

   logic [VALUE_PORT_W-1:0] pending_values[$];
   char_result_type         expected_chars[$];
   logic [BASE_W-1:0]       active_base = BASE_RESET;
   logic                    no_idle = 1'b0;

   int  send_gap = 0;
   logic offer_next;
   int  recv_wait = 0;
   int  hold_left = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   char_result_type oldest;

   int  error_count = 0;
   int  requests_taken = 0;
   int  chars_checked = 0;
   int  bad_base_requests = 0;
   int  base_settings = 1;

   radix_n_ascii_encoder_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_bad_base   (rsp_bad_base),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   // Expected characters for one request under the current base, most significant first
   function automatic void predict_digits(input logic [VALUE_PORT_W-1:0] value);
      logic [VALUE_PORT_W-1:0] rest;
      logic [VALUE_PORT_W-1:0] radix;
      logic [DIGIT_W-1:0]      rems[MAX_DIGITS];
      int                      n;
      if (active_base < BASE_MIN || active_base > BASE_MAX) begin
         expected_chars.push_back('{digit_char: CHAR_NONE, last: 1'b1, bad_base: 1'b1});
         bad_base_requests++;
         return;
      end
      radix = VALUE_PORT_W'(active_base);
      rest = value & VALUE_KEEP;
      n = 0;
      do begin
         rems[n] = DIGIT_W'(rest % radix);
         rest = rest / radix;
         n++;
      end while (rest != '0 && n < MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
         expected_chars.push_back('{digit_char: CHAR_W'(glyph_set[rems[k]]),
                                    last: (k == 0), bad_base: 1'b0});
      end
   endfunction

   // Request driver: offers queued values, random gap after each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offer_next = req_valid;
         if (req_valid && !req_stall) begin
            predict_digits(req_value);
            requests_taken++;
            offer_next = 1'b0;
            send_gap = draw_idle();
         end
         if (!offer_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_values.size() > 0) begin
               req_value <= pending_values.pop_front();
               offer_next = 1'b1;
            end
         end
         req_valid <= offer_next;
      end
   end

   // Result monitor: checks each character, draws its own stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = draw_idle();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
               $error("unexpected result: digit_char %0d last %0b bad_base %0b",
                      rsp_digit_char, rsp_last, rsp_bad_base);
               error_count++;
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_digit_char !== oldest.digit_char) begin
                  $error("digit_char: expected %0d, got %0d",
                         oldest.digit_char, rsp_digit_char);
                  error_count++;
               end
               if (rsp_last !== oldest.last) begin
                  $error("last: expected %0b, got %0b", oldest.last, rsp_last);
                  error_count++;
               end
               if (rsp_bad_base !== oldest.bad_base) begin
                  $error("bad_base: expected %0b, got %0b", oldest.bad_base, rsp_bad_base);
                  error_count++;
               end
            end
            recv_wait = draw_idle();
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait--;
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || (recv_wait > 0);
      end
   end

   task automatic offer(input logic [VALUE_PORT_W-1:0] v);
      pending_values.push_back(v);
   endtask

   // Block is idle once nothing is queued, offered or outstanding
   task automatic drain();
      do @(negedge clock);
      while (pending_values.size() != 0 || req_valid || expected_chars.size() != 0);
   endtask

   task automatic set_base(input logic [BASE_W-1:0] b);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= b;
      @(posedge clock);
      csr_write_en <= 1'b0;
      active_base = b;
      base_settings++;
      @(negedge clock);
   endtask

   function automatic logic [VALUE_PORT_W-1:0] rand_value();
      logic [VALUE_PORT_W-1:0] full;
      int                      w;
      full = {$urandom, $urandom};
      w = $urandom_range(1, VALUE_PORT_W);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return full >> (VALUE_PORT_W - w);
      endcase
   endfunction

   // Stimulus: directed phases per base, then random phases
   initial begin
      logic [BASE_W-1:0] b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset base 62: zero, largest single digit, rollover, full range
      offer('0);
      offer(61);
      offer(62);
      offer('1);
      offer(3843);
      offer(1);
      drain();

      // binary: longest output, top bit alone
      no_idle = 1'b1;
      set_base(BASE_MIN);
      offer('0);
      offer(1);
      offer('1);
      offer(64'h8000_0000_0000_0000);
      offer(5);
      drain();

      no_idle = 1'b0;
      set_base(10);
      offer('1);
      offer(9);
      offer(10);
      offer(1234567890);
      drain();

      set_base(16);
      offer(64'hDEAD_BEEF_0123_4567);
      offer(255);
      drain();

      // out-of-range bases give one flagged result
      set_base(0);
      offer('0);
      offer('1);
      drain();
      set_base(1);
      offer(7);
      drain();
      set_base(63);
      offer('0);
      offer('1);
      drain();

      set_base(36);
      offer(35);
      offer(36);
      drain();

      // random phases: binary, mid bases, any register value, top base, any valid base
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: b = BASE_MIN;
            1: b = BASE_W'($urandom_range(3, 61));
            2: b = BASE_W'($urandom_range(0, 63));
            3: b = BASE_MAX;
            default: b = BASE_W'($urandom_range(2, 62));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         set_base(b);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            offer(rand_value());
         end
         // receiver holds off while requests keep coming
         if (p == 1) begin
            hold_requests++;
         end
         drain();
      end

      repeat (200) @(negedge clock);
      $display("covered %0d requests in %0d base settings: %0d characters, %0d bad-base",
               requests_taken, base_settings, chars_checked, bad_base_requests);
      if (error_count == 0) begin
         $display("tb_radix_n_ascii_encoder_unit: done, clean");
      end else begin
         $display("tb_radix_n_ascii_encoder_unit: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("tb_radix_n_ascii_encoder_unit: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rne_pkg.sv
rtl/core/rne_serial_div.sv
rtl/core/rne_digit_stack.sv
rtl/core/radix_n_ascii_encoder_unit.sv
test/tb_radix_n_ascii_encoder_unit.sv
